/* rtl/hdp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hdp_pkg: HID descriptor usage parser shared types
// Item header fields, parse phases and the result record.
// ----------------------------------------------------------------------------
package hdp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER    = 2'd0,
    PH_DATA      = 2'd1,
    PH_LONG_LEN  = 2'd2,
    PH_LONG_SKIP = 2'd3
  } phase_e;

  // item types (header bits 3:2)
  localparam logic [1:0] ITEM_MAIN   = 2'd0;
  localparam logic [1:0] ITEM_GLOBAL = 2'd1;
  localparam logic [1:0] ITEM_LOCAL  = 2'd2;
  localparam logic [1:0] ITEM_LONG   = 2'd3;

  // item tags (header bits 7:4)
  localparam logic [3:0] TAG_COLLECTION = 4'hA;
  localparam logic [3:0] TAG_END_COLL   = 4'hC;
  localparam logic [3:0] TAG_LONG       = 4'hF;
  localparam logic [3:0] TAG_USAGE      = 4'h0;  // Usage Page for global, Usage for local

  localparam int unsigned DEPTH_W = 13;
  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 13'd8191;

  localparam logic RESULT_USAGE  = 1'b0;
  localparam logic RESULT_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] page;
    logic [15:0] usage;
    logic        malformed;
    logic        fin;
  } result_t;

  // data bytes that follow a short item header
  function automatic logic [2:0] size_bytes(input logic [1:0] code);
    logic [2:0] n;
    case (code)
      2'd0:    n = 3'd0;
      2'd1:    n = 3'd1;
      2'd2:    n = 3'd2;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/hid_descriptor_usage_parser_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hid_descriptor_usage_parser_top: top-level usage finder for HID descriptors
// Decodes a report descriptor byte stream and reports top-level collections.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one descriptor byte per request (tdata), tlast on the
//   final byte. Master side returns results: tuser = kind (0 usage pair,
//   1 end-of-descriptor status), tlast set on the status result.
//   Each byte is decoded in the cycle it is accepted; its results are
//   registered in the result queue. One byte per cycle is sustained while
//   the receiver keeps up; when the last byte completes a top-level
//   Collection item, the pair and the status are queued together, pair first.
//   A four-entry result queue sits between the sides, so the slave side stays
//   ready while up to two results wait on a stalled receiver; it drops ready
//   once three or more are queued and resumes as the receiver drains it.
//   Reset empties the queue and returns the parser to the start of a
//   descriptor; after each status result the parser also returns there.
//   Pairs reported before a malformed status are to be discarded.
// ----------------------------------------------------------------------------
module hid_descriptor_usage_parser_top #(
  parameter int unsigned MAX_DESCRIPTOR_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [15:0] usage page, [31:16] usage_id,
                                             // [32] malformed, [39:33] zero
  output logic             m_axis_tuser_o,   // result_kind
  output logic             m_axis_tlast_o    // final_result
);

  localparam int unsigned SEEN_W = $clog2(MAX_DESCRIPTOR_BYTES + 1);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_DESCRIPTOR_BYTES);

  // parser state
  hdp_pkg::phase_e           phase_q, phase_d;
  logic [7:0]                hdr_q, hdr_d;
  logic [15:0]               acc_q, acc_d;
  logic [8:0]                rem_q, rem_d;
  logic [SEEN_W-1:0]         seen_q, seen_d;
  logic [hdp_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic [15:0]               page_q, page_d;
  logic [15:0]               usage_q, usage_d;
  logic                      pend_q, pend_d;
  logic                      err_q, err_d;

  logic                      accept;
  logic                      do_finish;
  logic [7:0]                f_hdr;
  logic [15:0]               f_acc;
  logic [1:0]                f_type;
  logic [3:0]                f_tag;
  logic [1:0]                byte_idx;
  logic [2:0]                nbytes;
  logic [8:0]                skip_rem;
  logic                      emit_pair;
  logic                      emit_status;
  logic                      bad;

  hdp_pkg::result_t          res_a, res_b;
  logic [1:0]                n_wr;

  // result queue
  hdp_pkg::result_t          q_mem [4];
  logic [1:0]                wr_ptr_q, rd_ptr_q;
  logic [2:0]                cnt_q;
  logic                      pop;
  hdp_pkg::result_t          head;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (cnt_q <= 3'd2);

  always_comb begin
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    seen_d    = seen_q;
    depth_d   = depth_q;
    page_d    = page_q;
    usage_d   = usage_q;
    pend_d    = pend_q;
    err_d     = err_q;
    do_finish = 1'b0;
    f_hdr     = hdr_q;
    f_acc     = acc_q;
    emit_pair = 1'b0;
    byte_idx  = 2'd0;
    nbytes    = 3'd0;
    skip_rem  = rem_q;
    bad       = 1'b0;

    if (accept && !err_q) begin
      if (seen_q >= SEEN_MAX) begin
        err_d = 1'b1;
      end else begin
        seen_d = seen_q + 1'b1;
        case (phase_q)
          hdp_pkg::PH_HEADER: begin
            hdr_d = s_axis_tdata_i;
            acc_d = '0;
            if (s_axis_tdata_i[3:2] == hdp_pkg::ITEM_LONG &&
                s_axis_tdata_i[7:4] == hdp_pkg::TAG_LONG) begin
              phase_d = hdp_pkg::PH_LONG_LEN;
            end else begin
              nbytes = hdp_pkg::size_bytes(s_axis_tdata_i[1:0]);
              rem_d  = {6'd0, nbytes};
              if (nbytes == 3'd0) begin
                do_finish = 1'b1;
                f_hdr     = s_axis_tdata_i;
                f_acc     = '0;
              end else begin
                phase_d = hdp_pkg::PH_DATA;
              end
            end
          end
          hdp_pkg::PH_DATA: begin
            // only the low two value bytes are ever used
            byte_idx = 2'(hdp_pkg::size_bytes(hdr_q[1:0]) - rem_q[2:0]);
            if (byte_idx == 2'd0) begin
              acc_d[7:0] = s_axis_tdata_i;
            end else if (byte_idx == 2'd1) begin
              acc_d[15:8] = s_axis_tdata_i;
            end
            rem_d = rem_q - 1'b1;
            if (rem_q == 9'd1) begin
              phase_d   = hdp_pkg::PH_HEADER;
              do_finish = 1'b1;
              f_acc     = acc_d;
            end
          end
          hdp_pkg::PH_LONG_LEN: begin
            rem_d   = {1'b0, s_axis_tdata_i} + 9'd1;
            phase_d = hdp_pkg::PH_LONG_SKIP;
          end
          default: begin
            if (rem_q != 9'd0) begin
              skip_rem = rem_q - 1'b1;
            end
            rem_d = skip_rem;
            if (skip_rem == 9'd0) begin
              phase_d = hdp_pkg::PH_HEADER;
            end
          end
        endcase
      end
    end

    // execute a completed short item
    f_type = f_hdr[3:2];
    f_tag  = f_hdr[7:4];
    if (do_finish) begin
      if (f_type == hdp_pkg::ITEM_MAIN) begin
        if (f_tag == hdp_pkg::TAG_END_COLL) begin
          if (depth_q == '0) begin
            err_d = 1'b1;
          end else begin
            depth_d = depth_q - 1'b1;
          end
        end else begin
          if (depth_q == '0) begin
            emit_pair = (f_tag == hdp_pkg::TAG_COLLECTION) && pend_q;
            pend_d    = 1'b0;
          end
          if (f_tag == hdp_pkg::TAG_COLLECTION) begin
            if (depth_q >= hdp_pkg::DEPTH_LIMIT) begin
              err_d = 1'b1;
            end else begin
              depth_d = depth_q + 1'b1;
            end
          end
        end
      end else if (depth_q == '0 && f_tag == hdp_pkg::TAG_USAGE) begin
        if (f_type == hdp_pkg::ITEM_GLOBAL) begin
          page_d = f_acc;
        end else if (f_type == hdp_pkg::ITEM_LOCAL) begin
          usage_d = f_acc;
          pend_d  = 1'b1;
        end
      end
    end

    emit_status = accept && s_axis_tlast_i;
    if (emit_status) begin
      bad     = err_d || (phase_d != hdp_pkg::PH_HEADER);
      // return to the start of a descriptor
      phase_d = hdp_pkg::PH_HEADER;
      hdr_d   = '0;
      acc_d   = '0;
      rem_d   = '0;
      seen_d  = '0;
      depth_d = '0;
      page_d  = '0;
      usage_d = '0;
      pend_d  = 1'b0;
      err_d   = 1'b0;
    end
  end

  // results: pair first, then status
  always_comb begin
    res_a = '{kind: hdp_pkg::RESULT_USAGE, page: page_q, usage: usage_q,
              malformed: 1'b0, fin: 1'b0};
    res_b = '{kind: hdp_pkg::RESULT_STATUS, page: 16'd0, usage: 16'd0,
              malformed: bad, fin: 1'b1};
    n_wr  = 2'(emit_pair) + 2'(emit_status);
    if (!emit_pair) begin
      res_a = res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hdp_pkg::PH_HEADER;
      hdr_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      seen_q  <= '0;
      depth_q <= '0;
      page_q  <= '0;
      usage_q <= '0;
      pend_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      seen_q  <= seen_d;
      depth_q <= depth_d;
      page_q  <= page_d;
      usage_q <= usage_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
    end
  end

  assign pop  = m_axis_tvalid_o && m_axis_tready_i;
  assign head = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      q_mem[wr_ptr_q] <= res_a;
    end
    if (n_wr == 2'd2) begin
      q_mem[wr_ptr_q + 2'd1] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_wr;
      rd_ptr_q <= rd_ptr_q + 2'(pop);
      cnt_q    <= cnt_q + 3'(n_wr) - 3'(pop);
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tdata_o  = {7'd0, head.malformed, head.usage, head.page};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.fin;

endmodule
`default_nettype wire
